FILE: hw/rtl/rmsd_pkg.sv
package rmsd_pkg;

  localparam int PANEL_COLUMNS = 32;
  localparam int SCAN_ROWS     = 16;

  localparam int PANEL_ROWS  = 2 * SCAN_ROWS;
  localparam int HALF_DEPTH  = SCAN_ROWS * PANEL_COLUMNS;
  localparam int FIRST_LATCH = PANEL_COLUMNS;
  localparam int LAST_PHASE  = 2 * PANEL_COLUMNS + 1;

  localparam int COL_W     = $clog2(PANEL_COLUMNS);
  localparam int ROW_W     = $clog2(SCAN_ROWS);
  localparam int PHASE_W   = $clog2(LAST_PHASE + 1);
  localparam int HADDR_W   = $clog2(HALF_DEPTH);
  localparam int PIX_ROW_W = 5;
  localparam int PIX_COL_W = 5;
  localparam int COLOUR_W  = 3;
  localparam int OUT_ROW_W = 4;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_TICK  = 1'b1
  } rmsd_cmd_t;

  typedef struct packed {
    logic [OUT_ROW_W-1:0] row_address;
    logic                 show_pixel;
    logic                 shift_pulse;
    logic                 latch_pulse;
    logic                 frame_end;
  } rmsd_pins_t;

endpackage

FILE: hw/rtl/rmsd_scan_seq.sv
module rmsd_scan_seq import rmsd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  output rmsd_pins_t         pins,
  output logic [HADDR_W-1:0] rd_addr
);

  logic [ROW_W-1:0]   scan_row_r;
  logic [ROW_W-1:0]   scan_row_nxt;
  logic [PHASE_W-1:0] row_phase_r;
  logic [PHASE_W-1:0] row_phase_nxt;
  logic               last_phase;
  logic               last_row;

  assign last_phase = (row_phase_r == PHASE_W'(LAST_PHASE));
  assign last_row   = (scan_row_r == ROW_W'(SCAN_ROWS - 1));

  always_comb begin
    pins.row_address = OUT_ROW_W'(scan_row_r);
    pins.show_pixel  = (row_phase_r < PHASE_W'(FIRST_LATCH));
    pins.latch_pulse = (row_phase_r == PHASE_W'(FIRST_LATCH)) || last_phase;
    pins.shift_pulse = !pins.latch_pulse;
    pins.frame_end   = last_phase && last_row;
  end

  assign rd_addr = HADDR_W'(32'(scan_row_r) * PANEL_COLUMNS
                            + 32'(row_phase_r[COL_W-1:0]));

  always_comb begin
    scan_row_nxt  = scan_row_r;
    row_phase_nxt = row_phase_r;
    if (step) begin
      if (last_phase) begin
        row_phase_nxt = '0;
        scan_row_nxt  = last_row ? '0 : scan_row_r + 1'b1;
      end else begin
        row_phase_nxt = row_phase_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_row_r  <= '0;
      row_phase_r <= '0;
    end else begin
      scan_row_r  <= scan_row_nxt;
      row_phase_r <= row_phase_nxt;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_phase_r <= PHASE_W'(LAST_PHASE) && scan_row_r <= ROW_W'(SCAN_ROWS - 1))
    else $error("scan position out of range");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    step && pins.frame_end |=> scan_row_r == '0 && row_phase_r == '0)
    else $error("frame end did not wrap the scan");

endmodule

FILE: hw/rtl/rmsd_frame_store.sv
module rmsd_frame_store import rmsd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [PIX_ROW_W-1:0] wr_row,
  input  logic [PIX_COL_W-1:0] wr_col,
  input  logic [COLOUR_W-1:0]  wr_colour,
  input  logic                 rd_en,
  input  logic [HADDR_W-1:0]   rd_addr,
  output logic [COLOUR_W-1:0]  upper_q,
  output logic [COLOUR_W-1:0]  lower_q,
  output logic                 busy
);

  logic [COLOUR_W-1:0]  upper_mem [HALF_DEPTH];
  logic [COLOUR_W-1:0]  lower_mem [HALF_DEPTH];
  logic [COLOUR_W-1:0]  upper_q_r;
  logic [COLOUR_W-1:0]  lower_q_r;
  logic                 busy_r;
  logic [HADDR_W-1:0]   clr_idx_r;
  logic                 in_range;
  logic                 to_lower;
  logic [PIX_ROW_W-1:0] half_row;
  logic [HADDR_W-1:0]   pix_addr;
  logic                 we_upper;
  logic                 we_lower;
  logic [HADDR_W-1:0]   wa;
  logic [COLOUR_W-1:0]  wd;

  assign in_range = (32'(wr_row) < PANEL_ROWS) && (32'(wr_col) < PANEL_COLUMNS);
  assign to_lower = (32'(wr_row) >= SCAN_ROWS);
  assign half_row = to_lower ? PIX_ROW_W'(32'(wr_row) - SCAN_ROWS) : wr_row;
  assign pix_addr = HADDR_W'(32'(half_row) * PANEL_COLUMNS + 32'(wr_col));

  always_comb begin
    if (busy_r) begin
      we_upper = 1'b1;
      we_lower = 1'b1;
      wa       = clr_idx_r;
      wd       = '0;
    end else begin
      we_upper = wr_en && in_range && !to_lower;
      we_lower = wr_en && in_range && to_lower;
      wa       = pix_addr;
      wd       = wr_colour;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
    end else if (busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == HADDR_W'(HALF_DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we_upper) begin
      upper_mem[wa] <= wd;
    end
    if (we_lower) begin
      lower_mem[wa] <= wd;
    end
    if (rd_en) begin
      upper_q_r <= upper_mem[rd_addr];
      lower_q_r <= lower_mem[rd_addr];
    end
  end

  assign upper_q = upper_q_r;
  assign lower_q = lower_q_r;
  assign busy    = busy_r;

  a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !wr_en && !rd_en)
    else $error("frame store accessed during clearing pass");

endmodule

FILE: hw/rtl/rgb_matrix_scan_driver_unit.sv
// A tick item is registered in the input stage, then in the output register with its frame store read.
// Throughput: one item per cycle while in_stall is low; pixel writes and ticks mix freely and writes give no result.
// The output register holds a stalled result while a new item is still taken in.
// Reset is synchronous and active low; afterwards the frame store is cleared to black,
// one entry of each half a cycle over its 512 entries, and in_stall stays high until done.
module rgb_matrix_scan_driver_unit import rmsd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [PIX_ROW_W-1:0] in_pixel_row,
  input  logic [PIX_COL_W-1:0] in_pixel_column,
  input  logic [COLOUR_W-1:0]  in_pixel_colour,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_ROW_W-1:0] out_row_address,
  output logic [COLOUR_W-1:0]  out_upper_rgb,
  output logic [COLOUR_W-1:0]  out_lower_rgb,
  output logic                 out_shift_pulse,
  output logic                 out_latch_pulse,
  output logic                 out_frame_end
);

  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  rmsd_cmd_t            s1_cmd_r;
  logic [PIX_ROW_W-1:0] s1_row_r;
  logic [PIX_COL_W-1:0] s1_col_r;
  logic [COLOUR_W-1:0]  s1_colour_r;
  logic                 s2_valid_r;
  rmsd_pins_t           s2_pins_r;
  logic                 s2_free;
  logic                 s1_go;
  logic                 tick_go;
  logic                 write_go;
  logic                 in_take;
  logic                 busy;
  rmsd_pins_t           pins;
  logic [HADDR_W-1:0]   rd_addr;
  logic [COLOUR_W-1:0]  upper_q;
  logic [COLOUR_W-1:0]  lower_q;

  assign s2_free  = !s2_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (s1_cmd_r == CMD_WRITE || s2_free);
  assign tick_go  = s1_go && s1_cmd_r == CMD_TICK;
  assign write_go = s1_go && s1_cmd_r == CMD_WRITE;
  assign in_stall = busy || (s1_valid_r && !s1_go);
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s2_free) begin
        s2_valid_r <= tick_go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r    <= rmsd_cmd_t'(in_cmd);
      s1_row_r    <= in_pixel_row;
      s1_col_r    <= in_pixel_column;
      s1_colour_r <= in_pixel_colour;
    end
    if (tick_go) begin
      s2_pins_r <= pins;
    end
  end

  rmsd_scan_seq u_scan_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (tick_go),
    .pins    (pins),
    .rd_addr (rd_addr)
  );

  rmsd_frame_store u_frame_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (write_go),
    .wr_row    (s1_row_r),
    .wr_col    (s1_col_r),
    .wr_colour (s1_colour_r),
    .rd_en     (tick_go),
    .rd_addr   (rd_addr),
    .upper_q   (upper_q),
    .lower_q   (lower_q),
    .busy      (busy)
  );

  assign out_valid       = s2_valid_r;
  assign out_row_address = s2_pins_r.row_address;
  assign out_upper_rgb   = s2_pins_r.show_pixel ? upper_q : '0;
  assign out_lower_rgb   = s2_pins_r.show_pixel ? lower_q : '0;
  assign out_shift_pulse = s2_pins_r.shift_pulse;
  assign out_latch_pulse = s2_pins_r.latch_pulse;
  assign out_frame_end   = s2_pins_r.frame_end;

  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_stall && !s1_valid_r && !s2_valid_r)
    else $error("pipeline active during clearing pass");

endmodule
